// ----- sv/csl_pkg.sv -----
// shared types, constants and keyword table for the c subset lexer
`timescale 1ns / 1ps

package csl_pkg;

  // fixed widths of the result fields
  localparam int KIND_BITS  = 6;
  localparam int START_BITS = 16;
  localparam int LEN_BITS   = 6;

  // lexer sizing
  localparam int MAX_TOKEN_LEN = 63;
  localparam int POS_BITS      = 16;
  localparam int WORD_DEPTH    = 9;
  localparam int WIDX_BITS     = $clog2(WORD_DEPTH);
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  // result kinds
  localparam logic [KIND_BITS-1:0] KIND_INTEGER  = 6'd0;
  localparam logic [KIND_BITS-1:0] KIND_IDENT    = 6'd1;
  localparam logic [KIND_BITS-1:0] KIND_KEYWORD0 = 6'd2;
  localparam logic [KIND_BITS-1:0] KIND_PLUS     = 6'd34;
  localparam logic [KIND_BITS-1:0] KIND_MINUS    = 6'd35;
  localparam logic [KIND_BITS-1:0] KIND_STAR     = 6'd36;
  localparam logic [KIND_BITS-1:0] KIND_SLASH    = 6'd37;
  localparam logic [KIND_BITS-1:0] KIND_COMMA    = 6'd38;
  localparam logic [KIND_BITS-1:0] KIND_SEMI     = 6'd39;
  localparam logic [KIND_BITS-1:0] KIND_ASSIGN   = 6'd40;
  localparam logic [KIND_BITS-1:0] KIND_LPAREN   = 6'd41;
  localparam logic [KIND_BITS-1:0] KIND_RPAREN   = 6'd42;
  localparam logic [KIND_BITS-1:0] KIND_LBRACE   = 6'd43;
  localparam logic [KIND_BITS-1:0] KIND_RBRACE   = 6'd44;
  localparam logic [KIND_BITS-1:0] KIND_ERROR    = 6'd45;
  localparam logic [KIND_BITS-1:0] KIND_END      = 6'd46;

  // keyword table, text right justified, first character in the highest used byte
  localparam int KW_COUNT   = 32;
  localparam int KW_MAX_LEN = 8;
  localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "void", "char", "short", "int", "long", "float", "double", "auto",
    "static", "const", "signed", "unsigned", "extern", "volatile",
    "register", "return", "goto", "if", "else", "switch", "case",
    "default", "break", "for", "while", "do", "continue", "typedef",
    "struct", "enum", "union", "sizeof"
  };
  localparam int KW_LEN [KW_COUNT] = '{
    4, 4, 5, 3, 4, 5, 6, 4, 6, 5, 6, 8, 6, 8, 8, 6, 4, 2, 4, 6, 4,
    7, 5, 3, 5, 2, 8, 7, 6, 4, 5, 6
  };

  // pending token class
  typedef enum logic [2:0] {
    CLS_NONE = 3'b001,
    CLS_INT  = 3'b010,
    CLS_WORD = 3'b100
  } cls_t;

  typedef logic [WORD_DEPTH-1:0][7:0] word_t;

  // one result
  typedef struct packed {
    logic [KIND_BITS-1:0]  kind;
    logic [START_BITS-1:0] start;
    logic [LEN_BITS-1:0]   len;
  } res_t;

  // all results of one character, oldest in slot 0
  typedef struct packed {
    logic [1:0]     n;
    res_t [2:0]     r;
  } bundle_t;

  // keyword lookup on a pending word, identifier when nothing matches
  function automatic logic [KIND_BITS-1:0] kw_kind(word_t w, logic [LEN_BITS-1:0] len);
    logic [KIND_BITS-1:0] k;
    logic hit;
    k = KIND_IDENT;
    for (int i = 0; i < KW_COUNT; i++) begin
      hit = (len == LEN_BITS'(KW_LEN[i]));
      for (int j = 0; j < KW_MAX_LEN; j++) begin
        if (j < KW_LEN[i]) begin
          hit = hit & (w[j] == KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]);
        end
      end
      if (hit) begin
        k = KIND_KEYWORD0 + KIND_BITS'(i);
      end
    end
    return k;
  endfunction

endpackage

// ----- sv/csl_front.sv -----
// front end: accepts characters, tracks the pending token, builds result bundles
`timescale 1ns / 1ps

module csl_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          ch,
  input  logic                end_of_text,
  output logic                push,
  output csl_pkg::bundle_t    bundle
);
  import csl_pkg::*;

  cls_t                 cls, cls_next;
  logic [LEN_BITS-1:0]  len, len_next;
  logic [POS_BITS-1:0]  start, start_next;
  logic [POS_BITS-1:0]  pos, pos_next;
  logic                 disc, disc_next;
  word_t                word, word_next;

  logic                 is_dig, is_lead, is_sp;
  logic                 op_hit;
  logic [KIND_BITS-1:0] op_k;

  // character classes
  assign is_dig  = ch inside {["0":"9"]};
  assign is_lead = (ch inside {["a":"z"], ["A":"Z"]}) || (ch == "_");
  assign is_sp   = (ch == " ") || (ch == 8'h09) || (ch == 8'h0d) || (ch == 8'h0a);

  // operator decode
  always_comb begin
    op_hit = 1'b1;
    case (ch)
      "+":     op_k = KIND_PLUS;
      "-":     op_k = KIND_MINUS;
      "*":     op_k = KIND_STAR;
      "/":     op_k = KIND_SLASH;
      ",":     op_k = KIND_COMMA;
      ";":     op_k = KIND_SEMI;
      "=":     op_k = KIND_ASSIGN;
      "(":     op_k = KIND_LPAREN;
      ")":     op_k = KIND_RPAREN;
      "{":     op_k = KIND_LBRACE;
      "}":     op_k = KIND_RBRACE;
      default: begin
        op_k   = KIND_ERROR;
        op_hit = 1'b0;
      end
    endcase
  end

  // result of flushing a pending token
  function automatic res_t tok_res(cls_t c, logic [POS_BITS-1:0] s,
                                   logic [LEN_BITS-1:0] l, word_t w);
    res_t r;
    r.kind  = (c == CLS_INT) ? KIND_INTEGER : kw_kind(w, l);
    r.start = s[START_BITS-1:0];
    r.len   = l;
    return r;
  endfunction

  // per character update and bundle assembly
  always_comb begin
    cls_next   = cls;
    len_next   = len;
    start_next = start;
    pos_next   = pos;
    disc_next  = disc;
    word_next  = word;
    bundle     = '0;
    if (accept) begin
      pos_next = (pos == POS_MAX) ? pos : pos + POS_BITS'(1);
      if (!disc) begin
        if ((cls == CLS_INT && is_dig) || (cls == CLS_WORD && (is_lead || is_dig))) begin
          // extend the pending token
          if (len < LEN_BITS'(WORD_DEPTH)) begin
            word_next[len[WIDX_BITS-1:0]] = ch;
          end
          if (len < LEN_BITS'(MAX_TOKEN_LEN)) begin
            len_next = len + LEN_BITS'(1);
          end
        end else begin
          // close the pending token
          if (cls != CLS_NONE) begin
            bundle.r[bundle.n] = tok_res(cls, start, len, word);
            bundle.n = bundle.n + 2'd1;
          end
          cls_next = CLS_NONE;
          len_next = '0;
          if (is_sp) begin
            // separator only
          end else if (is_dig || is_lead) begin
            cls_next     = is_dig ? CLS_INT : CLS_WORD;
            start_next   = pos;
            len_next     = LEN_BITS'(1);
            word_next[0] = ch;
          end else if (op_hit) begin
            bundle.r[bundle.n] = '{kind: op_k, start: pos[START_BITS-1:0],
                                   len: LEN_BITS'(1)};
            bundle.n = bundle.n + 2'd1;
          end else begin
            bundle.r[bundle.n] = '{kind: KIND_ERROR, start: pos[START_BITS-1:0],
                                   len: LEN_BITS'(1)};
            bundle.n  = bundle.n + 2'd1;
            disc_next = 1'b1;
          end
        end
      end
      // end of text: last flush, end result, back to reset state
      if (end_of_text) begin
        if (!disc_next && cls_next != CLS_NONE) begin
          bundle.r[bundle.n] = tok_res(cls_next, start_next, len_next, word_next);
          bundle.n = bundle.n + 2'd1;
        end
        bundle.r[bundle.n] = '{kind: KIND_END, start: pos_next[START_BITS-1:0],
                               len: '0};
        bundle.n   = bundle.n + 2'd1;
        cls_next   = CLS_NONE;
        len_next   = '0;
        start_next = '0;
        pos_next   = '0;
        disc_next  = 1'b0;
      end
    end
  end

  assign push = accept && (bundle.n != 2'd0);

  // lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      cls   <= CLS_NONE;
      len   <= '0;
      start <= '0;
      pos   <= '0;
      disc  <= 1'b0;
    end else begin
      cls   <= cls_next;
      len   <= len_next;
      start <= start_next;
      pos   <= pos_next;
      disc  <= disc_next;
    end
  end

  // first characters of a pending word
  always_ff @(posedge clk) begin
    word <= word_next;
  end

endmodule

// ----- sv/csl_queue.sv -----
// short bundle queue between the front and back ends
`timescale 1ns / 1ps

module csl_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  csl_pkg::bundle_t  wdata,
  input  logic              pop,
  output csl_pkg::bundle_t  rdata,
  output logic              full,
  output logic              empty
);
  import csl_pkg::*;

  bundle_t               mem [QDEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]    count;

  assign full  = (count == (QPTR_BITS+1)'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (QPTR_BITS+1)'(1);
        2'b01:   count <= count - (QPTR_BITS+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/csl_back.sv -----
// back end: unpacks bundles into single result beats on the output register
`timescale 1ns / 1ps

module csl_back (
  input  logic                           clk,
  input  logic                           rst,
  input  csl_pkg::bundle_t               head,
  input  logic                           empty,
  output logic                           pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [csl_pkg::KIND_BITS-1:0]  kind,
  output logic [csl_pkg::START_BITS-1:0] start_res,
  output logic [csl_pkg::LEN_BITS-1:0]   length,
  output logic                           last_of_item
);
  import csl_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       is_last;

  // take the next result when the output register frees up
  assign load    = !empty && (!out_valid || !out_stall);
  assign is_last = (idx == head.n - 2'd1);
  assign pop     = load && is_last;

  // slot index within the head bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      kind         <= head.r[idx].kind;
      start_res    <= head.r[idx].start;
      length       <= head.r[idx].len;
      last_of_item <= is_last;
    end
  end

endmodule

// ----- sv/c_subset_lexer.sv -----
// top level of the c subset lexer
`timescale 1ns / 1ps

// Lexes a subset of C one ASCII character per beat and returns token beats of
// kind, start position and length; the flagged last character of a text
// closes it with an end beat. The input takes one character every cycle while
// the queue has room. A character yields zero to three result beats, and the
// output hands out one result beat per cycle while out_stall is low, so a
// burst of characters that each close tokens runs at the output rate of one
// result per cycle, with a four-entry bundle queue between the character front
// end and the output taking up the difference. Each character's results pass
// through the queue into the output register. No clearing pass is needed after reset.

module c_subset_lexer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     ch,
  input  logic                           end_of_text,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [csl_pkg::KIND_BITS-1:0]  kind,
  output logic [csl_pkg::START_BITS-1:0] start_res,
  output logic [csl_pkg::LEN_BITS-1:0]   length,
  output logic                           last_of_item
);
  import csl_pkg::*;

  logic    accept;
  logic    push, pop, full, empty;
  bundle_t wbundle, rbundle;

  // input beat taken while the queue has room
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  csl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .ch          (ch),
    .end_of_text (end_of_text),
    .push        (push),
    .bundle      (wbundle)
  );

  csl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (wbundle),
    .pop   (pop),
    .rdata (rbundle),
    .full  (full),
    .empty (empty)
  );

  csl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (rbundle),
    .empty        (empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .start_res    (start_res),
    .length       (length),
    .last_of_item (last_of_item)
  );

endmodule

// ----- sv/csl_checker.sv -----
// port level checks for the c subset lexer and their bind
`timescale 1ns / 1ps

module csl_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [csl_pkg::KIND_BITS-1:0]  kind,
  input logic [csl_pkg::START_BITS-1:0] start_res,
  input logic [csl_pkg::LEN_BITS-1:0]   length,
  input logic                           last_of_item
);
  import csl_pkg::*;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(start_res)
      && $stable(length) && $stable(last_of_item))
    else $error("stalled result beat changed");

  // no kind beyond end
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= KIND_END)
    else $error("result kind out of range");

  // end beat has zero length and closes its character
  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_END |-> length == '0 && last_of_item)
    else $error("malformed end beat");

  // operator and error beats are one character long
  a_op_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind >= KIND_PLUS && kind <= KIND_ERROR |-> length == LEN_BITS'(1))
    else $error("operator or error beat with wrong length");

  // integer, identifier and keyword beats are never empty
  a_tok_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind < KIND_PLUS |-> length != '0)
    else $error("empty token beat");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .kind         (kind),
  .start_res    (start_res),
  .length       (length),
  .last_of_item (last_of_item)
);
